// ----- src/packed_sample_unpack_scale_assert.svh -----
// Assertion macros for the packed sample unpacker checker.
// They expect signals named clk, rst_n, out_valid and out_ready in scope.
`ifndef PACKED_SAMPLE_UNPACK_SCALE_ASSERT_SVH
`define PACKED_SAMPLE_UNPACK_SCALE_ASSERT_SVH

// A property that is checked at every clock edge outside of reset.
`define PSUS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A condition that must hold in the cycle after an output transaction stalls.
`define PSUS_ASSERT_STALL(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (out_valid && !out_ready) |=> (cond)) \
        else $error(msg);

`endif

// ----- src/psus_pkg.sv -----
// Shared types, constants and decode helpers of the packed sample unpacker.
// No dependencies; used by the top level and by the checker.
`timescale 1ns / 1ps
`default_nettype none

package psus_pkg;

    localparam int MAX_CHANNELS = 1024;
    localparam int MAX_POLS     = 4;
    localparam int TABLE_DEPTH  = 4096;
    localparam int TABLE_AW     = $clog2(TABLE_DEPTH);

    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 11;
    localparam int WORD_W       = 16;
    localparam int COEF_W       = 32;
    localparam int VALUE_W      = 48;
    localparam int CH_W         = 10;
    localparam int POL_W        = 2;
    localparam int NCH_W        = 11;
    localparam int NPOL_W       = 3;
    localparam int HALVES_W     = 17;
    localparam int PROD_W       = HALVES_W + COEF_W;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BITS_MODE    = 3'd0,
        CFG_ZERO_OFFSET  = 3'd1,
        CFG_SCALING_EN   = 3'd2,
        CFG_CHANNELS     = 3'd3,
        CFG_POLS         = 3'd4
    } cfg_reg_t;

    localparam logic [2:0] MODE_1BIT  = 3'd0;
    localparam logic [2:0] MODE_2BIT  = 3'd1;
    localparam logic [2:0] MODE_4BIT  = 3'd2;
    localparam logic [2:0] MODE_8BIT  = 3'd3;
    localparam logic [2:0] MODE_16BIT = 3'd4;

    localparam logic KIND_RAW  = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    localparam logic [NCH_W-1:0]  MAX_CHANNELS_C = NCH_W'(MAX_CHANNELS);
    localparam logic [NPOL_W-1:0] MAX_POLS_C     = NPOL_W'(MAX_POLS);

    localparam logic signed [COEF_W-1:0]  SCALE_ONE = 32'sd65536;
    localparam logic signed [VALUE_W-1:0] SAT_MAX   = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] SAT_MIN   = {1'b1, {(VALUE_W-1){1'b0}}};

    // Two-bit codes map to -2, -0.5, 0.5 and 2, given here in half units.
    function automatic logic signed [HALVES_W-1:0] two_bit_halves(input logic [1:0] code);
        logic signed [HALVES_W-1:0] h;
        case (code)
            2'd0:    h = -17'sd4;
            2'd1:    h = -17'sd1;
            2'd2:    h = 17'sd1;
            default: h = 17'sd4;
        endcase
        return h;
    endfunction

endpackage

`default_nettype wire

// ----- src/packed_sample_unpack_scale.sv -----
// A data word is held in the word register; each of its samples then passes through the
// stage 1, stage 2 and stage 3 registers to the output. Throughput: one result per cycle
// while out_ready does not stall the pipeline; a word gives 8, 4 or 2 samples in 1, 2 or 4
// bit mode and one in the other modes. Table loads give no result.
// Reset clears the channel and pol counters and the pipeline and sets the registers to
// their defaults; the scale and offset tables are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module packed_sample_unpack_scale (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [psus_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [psus_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   kind,
    input  logic [psus_pkg::WORD_W-1:0]            raw_word,
    input  logic [psus_pkg::TABLE_AW-1:0]          table_index,
    input  logic signed [psus_pkg::COEF_W-1:0]     table_scale,
    input  logic signed [psus_pkg::COEF_W-1:0]     table_offset,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [psus_pkg::VALUE_W-1:0]    sample_value,
    output logic [psus_pkg::CH_W-1:0]              channel_number,
    output logic [psus_pkg::POL_W-1:0]             pol_number,
    output logic                                   last_of_word
);

    import psus_pkg::*;

    logic [2:0]        bits_mode_reg;
    logic [8:0]        zero_offset_reg;
    logic              scaling_en_reg;
    logic [NCH_W-1:0]  chans_reg;
    logic [NPOL_W-1:0] pols_reg;

    logic              item_v_reg;
    logic [WORD_W-1:0] data_reg;
    logic [2:0]        rem_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [POL_W-1:0]  po_reg;

    logic                       v1_reg;
    logic signed [HALVES_W-1:0] halves1_reg;
    logic [CH_W-1:0]            ch1_reg;
    logic [POL_W-1:0]           po1_reg;
    logic                       last1_reg;

    logic                       v2_reg;
    logic signed [PROD_W-1:0]   prod2_reg;
    logic signed [COEF_W-1:0]   offset2_reg;
    logic [CH_W-1:0]            ch2_reg;
    logic [POL_W-1:0]           po2_reg;
    logic                       last2_reg;

    logic                       v3_reg;
    logic signed [VALUE_W-1:0]  value3_reg;
    logic [CH_W-1:0]            ch3_reg;
    logic [POL_W-1:0]           po3_reg;
    logic                       last3_reg;

    logic adv1, adv2, adv3;
    logic issue, accept, take_word, load_we;

    logic [2:0]                 per_m1;
    logic [7:0]                 shift_next;
    logic [7:0]                 m;
    logic [8:0]                 zo;
    logic signed [HALVES_W-1:0] lin_halves;
    logic signed [HALVES_W-1:0] halves;

    logic [NCH_W-1:0]  nch;
    logic [NPOL_W-1:0] npo;
    logic [CH_W-1:0]   ch_cur;
    logic [POL_W-1:0]  po_cur;
    logic [NCH_W-1:0]  ch_plus;
    logic [NPOL_W-1:0] po_plus;
    logic [CH_W-1:0]   ch_next;
    logic [POL_W-1:0]  po_next;
    logic [TABLE_AW+1:0] idx_full;
    logic [TABLE_AW-1:0] idx;

    logic signed [COEF_W-1:0]  scale_rd, offset_rd;
    logic signed [COEF_W-1:0]  scale1, offset1;
    logic signed [PROD_W-1:0]  prod1;
    logic signed [PROD_W-1:0]  sum2;
    logic signed [VALUE_W-1:0] value2;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_mode_reg   <= MODE_8BIT;
            zero_offset_reg <= '0;
            scaling_en_reg  <= 1'b0;
            chans_reg       <= MAX_CHANNELS_C;
            pols_reg        <= NPOL_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BITS_MODE:   bits_mode_reg   <= cfg_data[2:0];
                CFG_ZERO_OFFSET: zero_offset_reg <= cfg_data[8:0];
                CFG_SCALING_EN:  scaling_en_reg  <= cfg_data[0];
                CFG_CHANNELS:    chans_reg       <= cfg_data[NCH_W-1:0];
                CFG_POLS:        pols_reg        <= cfg_data[NPOL_W-1:0];
                default:         ;
            endcase
        end
    end

    // Stall chain: each stage moves when its successor is empty or moving.
    assign adv3 = !v3_reg || out_ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign issue = item_v_reg && adv1;

    assign in_ready  = !item_v_reg || (issue && (rem_reg == 3'd0));
    assign accept    = in_valid && in_ready;
    assign take_word = accept && (kind == KIND_RAW);
    assign load_we   = accept && (kind == KIND_LOAD);

    // Per-mode sample extraction from the high bits of the working byte.
    always_comb
    begin
        per_m1     = 3'd0;
        shift_next = data_reg[7:0];
        m          = data_reg[7:0];
        case (bits_mode_reg)
            MODE_1BIT:
            begin
                per_m1     = 3'd7;
                shift_next = {data_reg[6:0], 1'b0};
                m          = {7'd0, data_reg[7]};
            end
            MODE_2BIT:
            begin
                per_m1     = 3'd3;
                shift_next = {data_reg[5:0], 2'b0};
                m          = {6'd0, data_reg[7:6]};
            end
            MODE_4BIT:
            begin
                per_m1     = 3'd1;
                shift_next = {data_reg[3:0], 4'b0};
                m          = {4'd0, data_reg[7:4]};
            end
            default:
            begin
                per_m1     = 3'd0;
                shift_next = data_reg[7:0];
                m          = data_reg[7:0];
            end
        endcase
    end

    assign zo         = scaling_en_reg ? zero_offset_reg : 9'd0;
    assign lin_halves = {8'd0, m, 1'b0} - {8'd0, zo};

    always_comb
    begin
        case (bits_mode_reg)
            MODE_2BIT:  halves = two_bit_halves(data_reg[7:6]);
            MODE_16BIT: halves = {data_reg, 1'b0};
            default:    halves = lin_halves;
        endcase
    end

    // Channel and pol position of the sample being issued.
    assign nch = (chans_reg == '0) ? NCH_W'(1)
               : (chans_reg > MAX_CHANNELS_C) ? MAX_CHANNELS_C : chans_reg;
    assign npo = (pols_reg == '0) ? NPOL_W'(1)
               : (pols_reg > MAX_POLS_C) ? MAX_POLS_C : pols_reg;

    assign ch_cur = ({1'b0, ch_reg} >= nch) ? '0 : ch_reg;
    assign po_cur = ({1'b0, po_reg} >= npo) ? '0 : po_reg;

    assign idx_full = (14'(po_cur) * 14'(nch)) + 14'(ch_cur);
    assign idx      = idx_full[TABLE_AW-1:0];

    assign ch_plus = {1'b0, ch_cur} + NCH_W'(1);
    assign po_plus = {1'b0, po_cur} + NPOL_W'(1);

    always_comb
    begin
        if (ch_plus >= nch)
        begin
            ch_next = '0;
            po_next = (po_plus >= npo) ? '0 : po_plus[POL_W-1:0];
        end
        else
        begin
            ch_next = ch_plus[CH_W-1:0];
            po_next = po_cur;
        end
    end

    // Word holding register and position counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_v_reg <= 1'b0;
            ch_reg     <= '0;
            po_reg     <= '0;
        end
        else
        begin
            if (take_word)
            begin
                item_v_reg <= 1'b1;
            end
            else if (issue && (rem_reg == 3'd0))
            begin
                item_v_reg <= 1'b0;
            end
            if (issue)
            begin
                ch_reg <= ch_next;
                po_reg <= po_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_word)
        begin
            data_reg <= raw_word;
            rem_reg  <= per_m1;
        end
        else if (issue)
        begin
            data_reg[7:0] <= shift_next;
            rem_reg       <= rem_reg - 3'd1;
        end
    end

    psus_ram #(
        .WIDTH (COEF_W),
        .DEPTH (TABLE_DEPTH)
    ) u_scale_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (table_index),
        .wdata (table_scale),
        .re    (adv1),
        .raddr (idx),
        .rdata (scale_rd)
    );

    psus_ram #(
        .WIDTH (COEF_W),
        .DEPTH (TABLE_DEPTH)
    ) u_offset_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (table_index),
        .wdata (table_offset),
        .re    (adv1),
        .raddr (idx),
        .rdata (offset_rd)
    );

    // Stage 1: table data arrives, multiply.
    assign scale1  = scaling_en_reg ? scale_rd : SCALE_ONE;
    assign offset1 = scaling_en_reg ? offset_rd : '0;
    assign prod1   = PROD_W'(halves1_reg) * PROD_W'(scale1);

    // Stage 2: halve with floor, add offset, saturate.
    assign sum2 = {prod2_reg[PROD_W-1], prod2_reg[PROD_W-1:1]} + PROD_W'(offset2_reg);

    always_comb
    begin
        if (sum2[PROD_W-1] != sum2[PROD_W-2])
        begin
            value2 = sum2[PROD_W-1] ? SAT_MIN : SAT_MAX;
        end
        else
        begin
            value2 = sum2[VALUE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= issue;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            halves1_reg <= halves;
            ch1_reg     <= ch_cur;
            po1_reg     <= po_cur;
            last1_reg   <= (rem_reg == 3'd0);
        end
        if (adv2)
        begin
            prod2_reg   <= prod1;
            offset2_reg <= offset1;
            ch2_reg     <= ch1_reg;
            po2_reg     <= po1_reg;
            last2_reg   <= last1_reg;
        end
        if (adv3)
        begin
            value3_reg <= value2;
            ch3_reg    <= ch2_reg;
            po3_reg    <= po2_reg;
            last3_reg  <= last2_reg;
        end
    end

    assign out_valid      = v3_reg;
    assign sample_value   = value3_reg;
    assign channel_number = ch3_reg;
    assign pol_number     = po3_reg;
    assign last_of_word   = last3_reg;

endmodule

`default_nettype wire

// ----- src/psus_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; holds the scale and offset tables.
`timescale 1ns / 1ps
`default_nettype none

module psus_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/psus_checker.sv -----
// Port-level assertions for the packed sample unpacker, bound to its top level.
// Depends on psus_pkg and on packed_sample_unpack_scale_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "packed_sample_unpack_scale_assert.svh"

module psus_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                kind,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [psus_pkg::VALUE_W-1:0] sample_value,
    input logic [psus_pkg::CH_W-1:0]           channel_number,
    input logic [psus_pkg::POL_W-1:0]          pol_number,
    input logic                                last_of_word
);

    import psus_pkg::*;

    logic seen_word_reg;

    // Set once a data word transaction has been taken since reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_word_reg <= 1'b0;
        end
        else if (in_valid && in_ready && (kind == KIND_RAW))
        begin
            seen_word_reg <= 1'b1;
        end
    end

    `PSUS_ASSERT_STALL(a_out_valid_holds, out_valid, "out_valid dropped while stalled")
    `PSUS_ASSERT_STALL(a_out_payload_holds,
        $stable(sample_value) && $stable(channel_number)
            && $stable(pol_number) && $stable(last_of_word),
        "result changed while stalled")
    `PSUS_ASSERT(a_no_result_without_word, out_valid |-> seen_word_reg,
        "result shown before any data word was taken")
    `PSUS_ASSERT(a_clean_after_reset, $rose(rst_n) |-> (!out_valid && in_ready),
        "block not empty and ready after reset")

endmodule

bind packed_sample_unpack_scale psus_checker u_psus_checker (.*);

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for packed_sample_unpack_scale: raw words and table loads go
// through a series of configurations, and every output sample is compared with a predictor.
// Depends on psus_pkg and the packed_sample_unpack_scale RTL.
`timescale 1ns / 1ps

module tb;
    import psus_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [2:0] MODE_RSVD5 = 3'd5;
    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;

    typedef struct {
        logic                kind;
        logic [WORD_W-1:0]   word;
        logic [TABLE_AW-1:0] index;
        logic [COEF_W-1:0]   scale;
        logic [COEF_W-1:0]   offset;
    } input_item_t;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic [CH_W-1:0]           channel;
        logic [POL_W-1:0]          pol;
        logic                      last;
    } sample_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      kind = KIND_RAW;
    logic [WORD_W-1:0]         raw_word = '0;
    logic [TABLE_AW-1:0]       table_index = '0;
    logic signed [COEF_W-1:0]  table_scale = '0;
    logic signed [COEF_W-1:0]  table_offset = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [VALUE_W-1:0] sample_value;
    logic [CH_W-1:0]           channel_number;
    logic [POL_W-1:0]          pol_number;
    logic                      last_of_word;

    logic [COEF_W-1:0] scale_mem [TABLE_DEPTH];
    logic [COEF_W-1:0] offset_mem [TABLE_DEPTH];
    bit                loaded [TABLE_DEPTH];
    int unsigned       chan_pos = 0;
    int unsigned       pol_pos = 0;
    logic [2:0]        width_code = MODE_8BIT;
    logic [8:0]        zero_halves = '0;
    logic              scaling_on = 1'b0;
    logic [10:0]       chan_setting = 11'd1024;
    logic [2:0]        pol_setting = 3'd1;

    input_item_t pending_items[$];
    input_item_t item_on_bus;
    input_item_t next_item;
    sample_t     expected_samples[$];
    sample_t     head_sample;
    int          gap_left = 0;
    int          stall_left = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          error_count = 0;
    int unsigned cycle_count = 0;
    bit          rand_scal = 1'b0;
    int unsigned rand_chans = 0;

    packed_sample_unpack_scale dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .raw_word       (raw_word),
        .table_index    (table_index),
        .table_scale    (table_scale),
        .table_offset   (table_offset),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample_value   (sample_value),
        .channel_number (channel_number),
        .pol_number     (pol_number),
        .last_of_word   (last_of_word)
    );

    function automatic int unsigned active_channels(logic [10:0] setting);
        if (setting == 0)
            return 1;
        if (setting > MAX_CHANNELS)
            return MAX_CHANNELS;
        return setting;
    endfunction

    function automatic int unsigned active_pols(logic [2:0] setting);
        if (setting == 0)
            return 1;
        if (setting > MAX_POLS)
            return MAX_POLS;
        return setting;
    endfunction

    function automatic void scale_and_queue(longint halves, logic last);
        int unsigned nch;
        int unsigned npo;
        int unsigned idx;
        longint      gain;
        longint      bias;
        longint      total;
        sample_t     s;
        nch = active_channels(chan_setting);
        npo = active_pols(pol_setting);
        if (chan_pos >= nch)
            chan_pos = 0;
        if (pol_pos >= npo)
            pol_pos = 0;
        idx = (pol_pos * nch + chan_pos) % TABLE_DEPTH;
        gain = 65536;
        bias = 0;
        if (scaling_on)
        begin
            gain = longint'(signed'(scale_mem[idx]));
            bias = longint'(signed'(offset_mem[idx]));
        end
        total = ((halves * gain) >>> 1) + bias;
        if (total > longint'(SAT_MAX))
            total = longint'(SAT_MAX);
        if (total < longint'(SAT_MIN))
            total = longint'(SAT_MIN);
        s.value = total[VALUE_W-1:0];
        s.channel = chan_pos[CH_W-1:0];
        s.pol = pol_pos[POL_W-1:0];
        s.last = last;
        expected_samples.push_back(s);
        if (chan_pos + 1 >= nch)
        begin
            chan_pos = 0;
            pol_pos = (pol_pos + 1 >= npo) ? 0 : pol_pos + 1;
        end
        else
        begin
            chan_pos = chan_pos + 1;
        end
    endfunction

    function automatic void predict_item(input_item_t it);
        longint      two_bit_lut [4] = '{-4, -1, 1, 4};
        int unsigned nbit;
        int unsigned per;
        int unsigned code;
        int unsigned k;
        longint      zo;
        longint      halves;
        if (it.kind == KIND_LOAD)
        begin
            scale_mem[it.index] = it.scale;
            offset_mem[it.index] = it.offset;
            return;
        end
        if (width_code == MODE_16BIT)
        begin
            scale_and_queue(2 * longint'(signed'(it.word)), 1'b1);
            return;
        end
        case (width_code)
            MODE_1BIT: nbit = 1;
            MODE_2BIT: nbit = 2;
            MODE_4BIT: nbit = 4;
            default:   nbit = 8;
        endcase
        per = 8 / nbit;
        zo = scaling_on ? longint'(zero_halves) : 0;
        for (k = 0; k < per; k++)
        begin
            code = (it.word[7:0] >> ((per - 1 - k) * nbit)) & ((1 << nbit) - 1);
            if (nbit == 2)
                halves = two_bit_lut[code];
            else
                halves = 2 * longint'(code) - zo;
            scale_and_queue(halves, k + 1 == per);
        end
    endfunction

    function automatic logic [COEF_W-1:0] random_coef();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0001_0000;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_word(logic [WORD_W-1:0] w);
        input_item_t it;
        it.kind = KIND_RAW;
        it.word = w;
        it.index = TABLE_AW'($urandom);
        it.scale = $urandom;
        it.offset = $urandom;
        pending_items.push_back(it);
    endfunction

    function automatic void push_load(int unsigned idx, logic [COEF_W-1:0] s,
                                      logic [COEF_W-1:0] o);
        input_item_t it;
        it.kind = KIND_LOAD;
        it.word = WORD_W'($urandom);
        it.index = idx[TABLE_AW-1:0];
        it.scale = s;
        it.offset = o;
        loaded[idx % TABLE_DEPTH] = 1'b1;
        pending_items.push_back(it);
    endfunction

    function automatic void push_random(int unsigned count);
        repeat (count)
        begin
            if ($urandom_range(0, 9) == 0)
                push_load($urandom_range(0, TABLE_DEPTH - 1), random_coef(), random_coef());
            else
                push_word(WORD_W'($urandom));
        end
    endfunction

    // Every entry that the current geometry can address gets written before any data word.
    function automatic void fill_tables();
        int unsigned nch;
        int unsigned npo;
        int unsigned p;
        int unsigned c;
        int unsigned idx;
        nch = active_channels(chan_setting);
        npo = active_pols(pol_setting);
        for (p = 0; p < npo; p++)
        begin
            for (c = 0; c < nch; c++)
            begin
                idx = (p * nch + c) % TABLE_DEPTH;
                if (!loaded[idx] || $urandom_range(0, 3) == 0)
                    push_load(idx, random_coef(), random_coef());
            end
        end
    endfunction

    task automatic check_field(string name, logic [63:0] want_val, logic [63:0] got_val);
        if (got_val !== want_val)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want_val, got_val);
        end
    endtask

    task automatic write_reg(cfg_reg_t which, int unsigned value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= which;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_until_drained();
        while (pending_items.size() > 0 || in_valid || expected_samples.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic setup_phase(logic [2:0] mode, int unsigned zo, bit scal, int unsigned ch,
                               int unsigned pol, int idle, int stall);
        wait_until_drained();
        write_reg(CFG_BITS_MODE, mode);
        write_reg(CFG_ZERO_OFFSET, zo);
        write_reg(CFG_SCALING_EN, scal);
        write_reg(CFG_CHANNELS, ch);
        write_reg(CFG_POLS, pol);
        width_code = mode;
        zero_halves = zo[8:0];
        scaling_on = scal;
        chan_setting = ch[10:0];
        pol_setting = pol[2:0];
        @(negedge clk);
        idle_pct = idle;
        stall_pct = stall;
        if (scal)
            fill_tables();
    endtask

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                predict_item(item_on_bus);
            if (in_valid && !in_ready)
            begin
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0 && $urandom_range(0, 99) < idle_pct)
            begin
                gap_left <= $urandom_range(0, 7);
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                next_item = pending_items.pop_front();
                item_on_bus <= next_item;
                kind <= next_item.kind;
                raw_word <= next_item.word;
                table_index <= next_item.index;
                table_scale <= next_item.scale;
                table_offset <= next_item.offset;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected transaction, expected none, actual %0h",
                             $time, sample_value);
                end
                else
                begin
                    head_sample = expected_samples.pop_front();
                    check_field("sample_value", head_sample.value, sample_value);
                    check_field("channel_number", head_sample.channel, channel_number);
                    check_field("pol_number", head_sample.pol, pol_number);
                    check_field("last_of_word", head_sample.last, last_of_word);
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                stall_left <= $urandom_range(0, 7);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset configuration: 8-bit samples, no scaling, 1024 channels, one pol.
        push_word(16'h0000);
        push_word(16'h00FF);
        push_word(16'hFF80);
        push_word(16'h7F01);
        push_random(20);

        setup_phase(MODE_1BIT, 0, 1'b0, 1024, 4, 25, 25);
        push_word(16'hFFFF);
        push_word(16'h0000);
        push_word(16'hA55A);
        push_random(30);

        setup_phase(MODE_2BIT, 511, 1'b1, 8, 2, 30, 10);
        push_load(0, 32'h8000_0000, 32'h8000_0000);
        push_load(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_word(16'h001B);
        push_word(16'hFFE4);
        push_random(30);

        setup_phase(MODE_4BIT, 511, 1'b1, 5, 3, 10, 40);
        push_word(16'h00F0);
        push_word(16'h000F);
        push_random(30);

        setup_phase(MODE_8BIT, 255, 1'b1, 3, 1, 40, 5);
        push_word(16'h0000);
        push_word(16'h00FF);
        push_random(30);

        setup_phase(MODE_16BIT, 100, 1'b1, 16, 4, 20, 20);
        push_word(16'h8000);
        push_word(16'h7FFF);
        push_word(16'hFFFF);
        push_word(16'h0000);
        push_random(30);

        setup_phase(MODE_RSVD7, 1, 1'b0, 0, 0, 15, 15);
        push_random(20);

        setup_phase(MODE_RSVD5, 0, 1'b0, 2047, 7, 10, 10);
        push_random(20);

        setup_phase(MODE_RSVD6, 300, 1'b1, 1, 1, 30, 30);
        push_random(20);

        setup_phase(MODE_1BIT, 511, 1'b1, 8, 3, 20, 20);
        push_random(20);

        repeat (4)
        begin
            rand_scal = 1'($urandom_range(0, 1));
            if (rand_scal)
                rand_chans = $urandom_range(0, 8);
            else
                rand_chans = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                         : $urandom_range(1, 20);
            setup_phase(3'($urandom_range(0, 7)), $urandom_range(0, 511), rand_scal,
                        rand_chans, $urandom_range(0, 7), $urandom_range(0, 40),
                        $urandom_range(0, 40));
            push_random(20);
        end

        setup_phase(MODE_2BIT, 0, 1'b0, 1024, 1, 0, 0);
        push_random(30);

        wait_until_drained();
        if (error_count == 0 && expected_samples.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
